// ===== hw/rtl/easter_holiday_check_assert.svh =====
// Assertion macros shared by the holiday check design.
`ifndef EASTER_HOLIDAY_CHECK_ASSERT_SVH
`define EASTER_HOLIDAY_CHECK_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked at every edge outside reset.
`define EHC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("easter_holiday_check: implication check failed");
// Next-cycle implication, also live during reset.
`define EHC_ASSERT_NEXT(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("easter_holiday_check: next-cycle check failed");
`else
`define EHC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define EHC_ASSERT_NEXT(name, clk, ante, cons)
`endif
`endif

// ===== hw/rtl/ehc_pkg.sv =====
// Types, constants and date helpers for the holiday check pipeline.
`default_nettype none
package ehc_pkg;

   // Reciprocal multipliers for division by constants (exact over the used ranges)
   localparam logic [12:0] DIV100_MUL = 13'd5243;  // y/100 = (y*5243) >> 19, y < 4096
   localparam logic [11:0] DIV19_MUL  = 12'd3450;  // y/19  = (y*3450) >> 16, y < 4096
   localparam logic [13:0] DIV7_MUL   = 14'd9363;  // x/7   = (x*9363) >> 16, x < 4096
   localparam logic [5:0]  DIV25_MUL  = 6'd41;     // x/25  = (x*41) >> 10, x < 334
   localparam logic [10:0] DIV30_MUL  = 11'd1093;  // x/30  = (x*1093) >> 15, x < 372
   localparam logic [5:0]  DIV7_SMALL_MUL = 6'd37; // x/7   = (x*37) >> 8, x < 45

   // Month numbers
   localparam logic [2:0] MONTH_MAR = 3'd3;
   localparam logic [2:0] MONTH_APR = 3'd4;
   localparam logic [2:0] MONTH_MAY = 3'd5;
   localparam logic [2:0] MONTH_JUN = 3'd6;
   localparam logic [2:0] MONTH_JUL = 3'd7;

   // Fixed-date holidays
   localparam int FIXED_COUNT = 5;
   localparam logic [4:0] FIXED_DAY [FIXED_COUNT] = '{5'd1, 5'd1, 5'd3, 5'd25, 5'd26};
   localparam logic [3:0] FIXED_MONTH [FIXED_COUNT] = '{4'd1, 4'd5, 4'd10, 4'd12, 4'd12};

   // Easter-relative holidays, in days from Easter Sunday
   localparam int SHIFT_COUNT = 4;
   localparam logic signed [7:0] EASTER_SHIFT [SHIFT_COUNT] =
      '{-8'sd2, 8'sd1, 8'sd39, 8'sd50};

   typedef struct packed {
      logic [2:0] month;
      logic [4:0] day;
   } date_type;

   // Year-derived terms after the first two stages
   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [4:0] a;
      logic [1:0] b;
      logic [2:0] c;
      logic [4:0] bigm;
      logic [5:0] u;
   } year_split_type;

   // Easter as days after March 1, with the date under test
   typedef struct packed {
      logic [4:0] day;
      logic [3:0] month;
      logic [5:0] easter;
   } easter_base_type;

   typedef struct packed {
      logic       holiday_flag;
      logic [2:0] easter_month;
      logic [4:0] easter_day;
   } result_type;

   // Days after March 1 to a calendar date, March to July
   function automatic date_type offset_to_date(input logic [6:0] off);
      date_type r;
      if (off < 7'd31) begin
         r.month = MONTH_MAR;
         r.day   = 5'(off + 7'd1);
      end else if (off < 7'd61) begin
         r.month = MONTH_APR;
         r.day   = 5'(off - 7'd30);
      end else if (off < 7'd92) begin
         r.month = MONTH_MAY;
         r.day   = 5'(off - 7'd60);
      end else if (off < 7'd122) begin
         r.month = MONTH_JUN;
         r.day   = 5'(off - 7'd91);
      end else begin
         r.month = MONTH_JUL;
         r.day   = 5'(off - 7'd121);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ehc_year_split.sv =====
// Stages 1-2: year divided down into the computus terms a, b, c, M and 6+s.
`default_nettype none
module ehc_year_split (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [4:0]             in_day,
   input  wire logic [3:0]             in_month,
   input  wire logic [11:0]            in_year,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ehc_pkg::year_split_type     out_data
);

   logic        s1_ready;
   logic        s2_ready;
   logic        s1_vld_ff;
   logic        s2_vld_ff;

   // Stage 1: reciprocal products for year/100, year/19 and year/7
   logic [24:0] k_prod;
   logic [23:0] q19_prod;
   logic [25:0] q7_prod;
   logic [5:0]  s1_k_in;
   logic [7:0]  s1_q19_in;
   logic [9:0]  s1_q7_in;
   logic [5:0]  s1_k_ff;
   logic [7:0]  s1_q19_ff;
   logic [9:0]  s1_q7_ff;
   logic [11:0] s1_year_ff;
   logic [4:0]  s1_day_ff;
   logic [3:0]  s1_month_ff;

   // Stage 2 terms
   logic [11:0] a_rem;
   logic [11:0] c_rem;
   logic [8:0]  m_x;
   logic [14:0] m_prod;
   logic [4:0]  mq;
   logic [3:0]  q4;
   logic [5:0]  t_sum;
   ehc_pkg::year_split_type s2_data_in;
   ehc_pkg::year_split_type s2_data_ff;

   // Ready chain: a stage takes an item when empty or when it is passing one on
   assign s2_ready = !s2_vld_ff || out_ready;
   assign s1_ready = !s1_vld_ff || s2_ready;
   assign in_ready = s1_ready;

   assign k_prod    = 25'(in_year) * 25'(ehc_pkg::DIV100_MUL);
   assign q19_prod  = 24'(in_year) * 24'(ehc_pkg::DIV19_MUL);
   assign q7_prod   = 26'(in_year) * 26'(ehc_pkg::DIV7_MUL);
   assign s1_k_in   = k_prod[24:19];
   assign s1_q19_in = q19_prod[23:16];
   assign s1_q7_in  = q7_prod[25:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_k_ff     <= s1_k_in;
         s1_q19_ff   <= s1_q19_in;
         s1_q7_ff    <= s1_q7_in;
         s1_year_ff  <= in_year;
         s1_day_ff   <= in_day;
         s1_month_ff <= in_month;
      end
   end

   // Stage 2: remainders, then M and 6+s from the century k alone
   always_comb begin
      a_rem  = s1_year_ff - 12'(12'(s1_q19_ff) * 12'd19);
      c_rem  = s1_year_ff - 12'(12'(s1_q7_ff) * 12'd7);
      m_x    = {s1_k_ff, 3'b000} + 9'd13;
      m_prod = 15'(m_x) * 15'(ehc_pkg::DIV25_MUL);
      mq     = m_prod[14:10];
      q4     = s1_k_ff[5:2];
      // 15 + s - m with the two offsets of -2 cancelled
      t_sum  = 6'd15 + s1_k_ff - 6'(q4) - 6'(mq);

      s2_data_in.day   = s1_day_ff;
      s2_data_in.month = s1_month_ff;
      s2_data_in.a     = a_rem[4:0];
      s2_data_in.b     = s1_year_ff[1:0];
      s2_data_in.c     = c_rem[2:0];
      s2_data_in.bigm  = (t_sum >= 6'd30) ? 5'(t_sum - 6'd30) : t_sum[4:0];
      s2_data_in.u     = 6'd4 + s1_k_ff - 6'(q4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_vld_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_data  = s2_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ehc_computus.sv =====
// Stages 3-5: d, the D correction, e and Easter as days after March 1.
`default_nettype none
module ehc_computus (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire ehc_pkg::year_split_type in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output ehc_pkg::easter_base_type     out_data
);

   logic        s3_ready;
   logic        s4_ready;
   logic        s5_ready;
   logic        s3_vld_ff;
   logic        s4_vld_ff;
   logic        s5_vld_ff;

   // Stage 3 signals
   logic [8:0]  s3_x_in;
   logic [19:0] dq_prod;
   logic [11:0] nq_prod;
   logic [3:0]  nq;
   logic [5:0]  bign_full;
   logic [8:0]  s3_x_ff;
   logic [4:0]  s3_dq_ff;
   logic [2:0]  s3_bign_ff;
   logic [4:0]  s3_a_ff;
   logic [1:0]  s3_b_ff;
   logic [2:0]  s3_c_ff;
   logic [4:0]  s3_day_ff;
   logic [3:0]  s3_month_ff;

   // Stage 4 signals
   logic [8:0]  d_full;
   logic [4:0]  d_val;
   logic [4:0]  s4_bd_in;
   logic [7:0]  s4_w_in;
   logic [4:0]  s4_bd_ff;
   logic [7:0]  s4_w_ff;
   logic [4:0]  s4_day_ff;
   logic [3:0]  s4_month_ff;

   // Stage 5 signals
   logic [21:0] eq_prod;
   logic [5:0]  eq;
   logic [7:0]  e_full;
   ehc_pkg::easter_base_type s5_data_in;
   ehc_pkg::easter_base_type s5_data_ff;

   assign s5_ready = !s5_vld_ff || out_ready;
   assign s4_ready = !s4_vld_ff || s5_ready;
   assign s3_ready = !s3_vld_ff || s4_ready;
   assign in_ready = s3_ready;

   // Stage 3: M + 19a with its quotient by 30, and N = (6+s) mod 7
   always_comb begin
      s3_x_in   = 9'(in_data.bigm) + 9'(9'(in_data.a) * 9'd19);
      dq_prod   = 20'(s3_x_in) * 20'(ehc_pkg::DIV30_MUL);
      nq_prod   = 12'(in_data.u) * 12'(ehc_pkg::DIV7_SMALL_MUL);
      nq        = nq_prod[11:8];
      bign_full = in_data.u - 6'(6'(nq) * 6'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_x_ff     <= s3_x_in;
         s3_dq_ff    <= dq_prod[19:15];
         s3_bign_ff  <= bign_full[2:0];
         s3_a_ff     <= in_data.a;
         s3_b_ff     <= in_data.b;
         s3_c_ff     <= in_data.c;
         s3_day_ff   <= in_data.day;
         s3_month_ff <= in_data.month;
      end
   end

   // Stage 4: d, the late-April corrections, and the weekday sum for e
   always_comb begin
      d_full = s3_x_ff - 9'(9'(s3_dq_ff) * 9'd30);
      d_val  = d_full[4:0];
      if (d_val == 5'd29) begin
         s4_bd_in = 5'd28;
      end else if (d_val == 5'd28 && s3_a_ff >= 5'd11) begin
         s4_bd_in = 5'd27;
      end else begin
         s4_bd_in = d_val;
      end
      s4_w_in = 8'({s3_b_ff, 1'b0}) + 8'({s3_c_ff, 2'b00})
              + 8'(8'(s4_bd_in) * 8'd6) + 8'(s3_bign_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_vld_ff) begin
         s4_bd_ff    <= s4_bd_in;
         s4_w_ff     <= s4_w_in;
         s4_day_ff   <= s3_day_ff;
         s4_month_ff <= s3_month_ff;
      end
   end

   // Stage 5: e = sum mod 7, Easter = 21 + D + e days after March 1
   always_comb begin
      eq_prod = 22'(s4_w_ff) * 22'(ehc_pkg::DIV7_MUL);
      eq      = eq_prod[21:16];
      e_full  = s4_w_ff - 8'(8'(eq) * 8'd7);
      s5_data_in.day    = s4_day_ff;
      s5_data_in.month  = s4_month_ff;
      s5_data_in.easter = 6'd21 + 6'(s4_bd_ff) + 6'(e_full[2:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && s4_vld_ff) begin
         s5_data_ff <= s5_data_in;
      end
   end

   assign out_valid = s5_vld_ff;
   assign out_data  = s5_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ehc_holiday_match.sv =====
// Stage 6: Easter date, holiday dates and the match, into the output register.
`default_nettype none
module ehc_holiday_match (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire ehc_pkg::easter_base_type in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output ehc_pkg::result_type           out_data
);

   logic                     out_vld_ff;
   ehc_pkg::result_type      out_data_in;
   ehc_pkg::result_type      out_data_ff;
   ehc_pkg::date_type        easter_date;
   logic signed [7:0]        shift_sum [ehc_pkg::SHIFT_COUNT];
   ehc_pkg::date_type        shift_date [ehc_pkg::SHIFT_COUNT];
   logic                     hit;

   assign in_ready = !out_vld_ff || out_ready;

   // Compare the item's date with the fixed and the Easter-relative holidays
   always_comb begin
      easter_date = ehc_pkg::offset_to_date({1'b0, in_data.easter});
      hit = 1'b0;
      for (int i = 0; i < ehc_pkg::FIXED_COUNT; i++) begin
         if (in_data.day == ehc_pkg::FIXED_DAY[i] && in_data.month == ehc_pkg::FIXED_MONTH[i]) begin
            hit = 1'b1;
         end
      end
      for (int j = 0; j < ehc_pkg::SHIFT_COUNT; j++) begin
         shift_sum[j]  = $signed({2'b00, in_data.easter}) + ehc_pkg::EASTER_SHIFT[j];
         shift_date[j] = ehc_pkg::offset_to_date(shift_sum[j][6:0]);
         if (in_data.day == shift_date[j].day && in_data.month == {1'b0, shift_date[j].month}) begin
            hit = 1'b1;
         end
      end
      out_data_in.holiday_flag = hit;
      out_data_in.easter_month = easter_date.month;
      out_data_in.easter_day   = easter_date.day;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (in_ready) begin
         out_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/easter_holiday_check.sv =====
// Top level of the holiday check: Gauss Easter computus and holiday match, six stages.
// Path: an accepted item passes through six registers, those of stages 1 to 5 and the output register.
// Throughput: one item per cycle while rsp_ready is high; each stage has its own valid bit and moves when free.
// Stall: a full stage holds its item while the one after it is stalled; nothing is dropped.
// Reset: synchronous, clears the valid bits only; no other state is kept between items.
`default_nettype none
`include "easter_holiday_check_assert.svh"
module easter_holiday_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_day_of_month,
   input  wire logic [3:0]  req_month_number,
   input  wire logic [11:0] req_year_number,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_holiday_flag,
   output logic [2:0]       rsp_easter_month,
   output logic [4:0]       rsp_easter_day
);

   logic                     split_valid;
   logic                     split_ready;
   ehc_pkg::year_split_type  split_data;
   logic                     base_valid;
   logic                     base_ready;
   ehc_pkg::easter_base_type base_data;
   ehc_pkg::result_type      result;

   ehc_year_split u_year_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_day    (req_day_of_month),
      .in_month  (req_month_number),
      .in_year   (req_year_number),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   ehc_computus u_computus (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (base_valid),
      .out_ready (base_ready),
      .out_data  (base_data)
   );

   ehc_holiday_match u_holiday_match (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (base_valid),
      .in_ready  (base_ready),
      .in_data   (base_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (result)
   );

   assign rsp_holiday_flag = result.holiday_flag;
   assign rsp_easter_month = result.easter_month;
   assign rsp_easter_day   = result.easter_day;

   // Easter always lands between March 22 and April 25
   `EHC_ASSERT_IMPLY(a_easter_window, clock, reset, rsp_valid, (rsp_easter_month == ehc_pkg::MONTH_MAR && rsp_easter_day >= 5'd22) || (rsp_easter_month == ehc_pkg::MONTH_APR && rsp_easter_day >= 5'd1 && rsp_easter_day <= 5'd25))
   // With the output side taking items the whole pipeline must take a new one
   `EHC_ASSERT_IMPLY(a_no_bubble_stall, clock, reset, rsp_ready, req_ready)
   // Reset empties the output register
   `EHC_ASSERT_NEXT(a_reset_clears, clock, reset, !rsp_valid)

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the Easter computus and holiday check pipeline.
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int LONG_HOLD_AT  = 300;
   localparam int LONG_HOLD_LEN = 300;

   // Easter-relative holidays, days from Easter Sunday
   localparam int GOOD_FRIDAY   = -2;
   localparam int EASTER_MONDAY = 1;
   localparam int ASCENSION     = 39;
   localparam int WHIT_MONDAY   = 50;
   localparam int FIXED_HOLIDAYS = 5;
   localparam int ALL_HOLIDAYS   = 9;

   typedef struct {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
   } test_date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_day_of_month = '0;
   logic [3:0]  req_month_number = '0;
   logic [11:0] req_year_number = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_holiday_flag;
   logic [2:0]  rsp_easter_month;
   logic [4:0]  rsp_easter_day;

   test_date_type          pending_dates[$];
   ehc_pkg::result_type    expected_results[$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;

   easter_holiday_check u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_day_of_month (req_day_of_month),
      .req_month_number (req_month_number),
      .req_year_number  (req_year_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_holiday_flag (rsp_holiday_flag),
      .rsp_easter_month (rsp_easter_month),
      .rsp_easter_day   (rsp_easter_day)
   );

   always #2 clock = ~clock;

   // Gauss's rule: Easter Sunday as days after March 1 (March 1 is 0)
   function automatic int easter_days_after_mar1(input int yr);
      int a, b, c, k, m, s, big_m, big_n, d, d_fixed, e;
      a = yr % 19;
      b = yr % 4;
      c = yr % 7;
      k = yr / 100;
      m = (8 * k + 13) / 25 - 2;
      s = k - yr / 400 - 2;
      big_m = (15 + s - m) % 30;
      big_n = (6 + s) % 7;
      d = (big_m + 19 * a) % 30;
      if (d == 29)
         d_fixed = 28;
      else if (d == 28 && a >= 11)
         d_fixed = 27;
      else
         d_fixed = d;
      e = (2 * b + 4 * c + 6 * d_fixed + big_n) % 7;
      return 21 + d_fixed + e;
   endfunction

   // Day count from March 1 to day and month, walking March to July
   function automatic void days_to_date(input int off, output int dd, output int mm);
      int idx;
      int len;
      idx = 0;
      len = 31;
      while (idx < 4 && off >= len) begin
         off -= len;
         idx++;
         len = (idx == 1 || idx == 3) ? 30 : 31;
      end
      dd = off + 1;
      mm = idx + 3;
   endfunction

   function automatic int easter_shift(input int which);
      case (which)
         0: return GOOD_FRIDAY;
         1: return EASTER_MONDAY;
         2: return ASCENSION;
         default: return WHIT_MONDAY;
      endcase
   endfunction

   // Holiday number 0..4 are the fixed dates, 5..8 follow Easter
   function automatic test_date_type holiday_date(input int yr, input int which);
      test_date_type t;
      int dd, mm;
      t.year = 12'(yr);
      case (which)
         0: begin dd = 1;  mm = 1;  end
         1: begin dd = 1;  mm = 5;  end
         2: begin dd = 3;  mm = 10; end
         3: begin dd = 25; mm = 12; end
         4: begin dd = 26; mm = 12; end
         default: days_to_date(easter_days_after_mar1(yr) +
                               easter_shift(which - FIXED_HOLIDAYS), dd, mm);
      endcase
      t.day   = 5'(dd);
      t.month = 4'(mm);
      return t;
   endfunction

   function automatic ehc_pkg::result_type predict_holiday_result(
      input logic [4:0] day, input logic [3:0] month, input logic [11:0] year);
      ehc_pkg::result_type r;
      test_date_type h;
      int easter, ed, em;
      easter = easter_days_after_mar1(int'(year));
      days_to_date(easter, ed, em);
      r.holiday_flag = 1'b0;
      for (int i = 0; i < ALL_HOLIDAYS; i++) begin
         h = holiday_date(int'(year), i);
         if (h.day == day && h.month == month)
            r.holiday_flag = 1'b1;
      end
      r.easter_month = 3'(em);
      r.easter_day   = 5'(ed);
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long
   function automatic int pick_idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic test_date_type make_date(input int dd, input int mm, input int yr);
      test_date_type t;
      t.day   = 5'(dd);
      t.month = 4'(mm);
      t.year  = 12'(yr);
      return t;
   endfunction

   task automatic compare_field(input string what, input logic [4:0] want,
                                input logic [4:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Driver: offers queued items, with random gaps and gap-free bursts
   int            send_idle = 0;
   int            send_burst = 0;
   test_date_type next_date;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(predict_holiday_result(
               req_day_of_month, req_month_number, req_year_number));
         if (!req_valid || req_ready) begin
            if (send_idle > 0) begin
               send_idle--;
               req_valid <= 1'b0;
            end else if (pending_dates.size() != 0) begin
               next_date = pending_dates.pop_front();
               req_valid        <= 1'b1;
               req_day_of_month <= next_date.day;
               req_month_number <= next_date.month;
               req_year_number  <= next_date.year;
               if (send_burst > 0) begin
                  send_burst--;
                  send_idle = 0;
               end else begin
                  if ($urandom_range(0, 39) == 0)
                     send_burst = $urandom_range(20, 80);
                  send_idle = pick_idle_len();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each item taken, stalls at random, one long hold-off
   int                  hold_left = 0;
   int                  take_burst = 0;
   int                  results_seen = 0;
   bit                  long_hold_done = 1'b0;
   ehc_pkg::result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with none expected, flag %0d month %0d day %0d",
                        $time, rsp_holiday_flag, rsp_easter_month, rsp_easter_day);
            end else begin
               want = expected_results.pop_front();
               compare_field("holiday_flag", 5'(want.holiday_flag), 5'(rsp_holiday_flag));
               compare_field("easter_month", 5'(want.easter_month), 5'(rsp_easter_month));
               compare_field("easter_day", want.easter_day, rsp_easter_day);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            // long hold-off so the pipeline fills and backs up the input
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_LEN - 1;
            rsp_ready <= 1'b0;
         end else if (take_burst > 0) begin
            take_burst--;
            rsp_ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 59) == 0)
               take_burst = $urandom_range(20, 80);
            hold_left = ($urandom_range(0, 99) < 30) ? pick_idle_len() : 0;
            if (hold_left > 0) begin
               hold_left--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int r, yr;
      test_date_type t;

      // field extremes and impossible dates
      pending_dates.push_back(make_date(0, 0, 0));
      pending_dates.push_back(make_date(31, 15, 4095));
      pending_dates.push_back(make_date(31, 12, 4095));
      pending_dates.push_back(make_date(1, 1, 1583));
      pending_dates.push_back(make_date(30, 2, 2000));
      pending_dates.push_back(make_date(31, 4, 2000));
      pending_dates.push_back(make_date(0, 5, 2000));
      pending_dates.push_back(make_date(1, 13, 2000));
      // year 0: formula still applies below 1583
      pending_dates.push_back(holiday_date(0, 5));
      // fixed holidays
      for (int i = 1; i < FIXED_HOLIDAYS; i++)
         pending_dates.push_back(holiday_date(2000, i));
      // d = 29 correction: all shifted holidays plus Easter itself
      for (int i = FIXED_HOLIDAYS; i < ALL_HOLIDAYS; i++)
         pending_dates.push_back(holiday_date(1981, i));
      pending_dates.push_back(make_date(19, 4, 1981));
      // d = 28 with a >= 11 correction
      pending_dates.push_back(holiday_date(1954, 6));
      // earliest Easter: Good Friday two days before March 22
      pending_dates.push_back(holiday_date(2285, 5));
      // shifted holidays carried across a month end
      pending_dates.push_back(holiday_date(2018, 5));
      pending_dates.push_back(holiday_date(2024, 6));
      pending_dates.push_back(holiday_date(2038, 8));

      // random part: holidays and their neighbours, plain dates, raw noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r  = $urandom_range(0, 99);
         yr = $urandom_range(1583, 4095);
         if (r < 35) begin
            t = holiday_date(yr, $urandom_range(0, ALL_HOLIDAYS - 1));
            if ($urandom_range(0, 4) == 0)
               t.day = ($urandom_range(0, 1) == 0) ? t.day + 5'd1 : t.day - 5'd1;
         end else if (r < 75) begin
            t = make_date($urandom_range(1, 31), $urandom_range(1, 12), yr);
         end else begin
            t = make_date($urandom_range(0, 31), $urandom_range(0, 15),
                          $urandom_range(0, 4095));
         end
         pending_dates.push_back(t);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ehc_pkg.sv
hw/rtl/ehc_year_split.sv
hw/rtl/ehc_computus.sv
hw/rtl/ehc_holiday_match.sv
hw/rtl/easter_holiday_check.sv
tb/tb.sv
